// ===== sv/rast_pkg.sv =====
package rast_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int LEN_RESET        = 1024;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_ASSIGN = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         left_index;
        logic [9:0]         right_index;
        logic signed [31:0] operand_value;
    } cmd_t;

    typedef struct packed {
        logic signed [63:0] range_sum;
        logic               status;
    } res_t;

endpackage

// ===== sv/rast_mem.sv =====
module rast_mem #(
    parameter int DEPTH = rast_pkg::DEF_MAX_ELEMENTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [63:0]   wdata,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/rast_alu.sv =====
module rast_alu (
    input  logic        sel_acc,
    input  logic [63:0] rd_data,
    input  logic [63:0] operand,
    input  logic [63:0] acc,
    output logic [63:0] sum
);

    // shared 64-bit adder: element update or running query total
    assign sum = rd_data + (sel_acc ? acc : operand);

endmodule

// ===== sv/range_add_assign_sum_tree.sv =====
// Range add / range assign / range sum over a signed 64-bit array.
// Command channel: cmd is transferred at a clock edge with start high,
// busy low and cfg_wr_en low. Add and assign on a valid range give no
// result; a query gives one result, and any bad range or unknown kind
// gives one result with status set and a zero sum. done flags the result
// for exactly one cycle and res keeps it; the receiver cannot stall it.
// Elements live flat in a single-port memory, stepped through one at a
// time by a small sequencer around one shared 64-bit adder.
// Per command: assign writes each element of the range in turn; add and
// query read then modify each element in turn (S_READ, S_MOD), and a
// query has done high in the first cycle that busy is low. A bad request
// leaves busy low, with done in the cycle after the transfer.
// The memory port is the limit: an add or query needs a read then a write
// or accumulate per element.
// Reset and a cfg write while idle start a clearing pass over every
// entry, busy throughout; a write during a clearing pass restarts it,
// one while a command runs is ignored. Length resets to 1024 (capped at
// MAX_ELEMENTS); a written 0 is taken as 1, above MAX_ELEMENTS as the cap.
module range_add_assign_sum_tree #(
    parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rast_pkg::cmd_t cmd,
    output logic           done,
    output rast_pkg::res_t res,
    input  logic           cfg_wr_en,
    input  logic [10:0]    cfg_wr_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    localparam int CW = (LW > 10) ? LW : 10;
    localparam int VW = (LW > 11) ? LW : 11;
    localparam int LEN_INIT = (rast_pkg::LEN_RESET > MAX_ELEMENTS) ?
                              MAX_ELEMENTS : rast_pkg::LEN_RESET;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_ASSIGN = 5'b00100,
        S_READ   = 5'b01000,
        S_MOD    = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  last_reg, last_next;
    logic [1:0]     kind_reg, kind_next;
    logic [63:0]    val_reg, val_next;
    logic [63:0]    acc_reg, acc_next;
    logic           done_reg, done_next;
    rast_pkg::res_t res_reg, res_next;

    logic           mem_we;
    logic [63:0]    mem_wdata;
    logic [63:0]    mem_rdata;
    logic [63:0]    alu_sum;
    logic           bad_req;
    logic [VW-1:0]  cfg_ext;
    logic [LW-1:0]  cfg_len;
    logic           at_last;

    rast_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (idx_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    rast_alu u_alu (
        .sel_acc (kind_reg == rast_pkg::KIND_QUERY),
        .rd_data (mem_rdata),
        .operand (val_reg),
        .acc     (acc_reg),
        .sum     (alu_sum)
    );

    // bad kind, reversed range, or range past the active length
    assign bad_req = (cmd.kind != rast_pkg::KIND_ADD &&
                      cmd.kind != rast_pkg::KIND_ASSIGN &&
                      cmd.kind != rast_pkg::KIND_QUERY) ||
                     (cmd.left_index > cmd.right_index) ||
                     (CW'(cmd.right_index) >= CW'(len_reg));

    // clamp the written length into 1 .. MAX_ELEMENTS
    assign cfg_ext = VW'(cfg_wr_data);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cfg_len = LW'(1);
        end
        else if (cfg_ext > VW'(MAX_ELEMENTS))
        begin
            cfg_len = LW'(MAX_ELEMENTS);
        end
        else
        begin
            cfg_len = LW'(cfg_ext);
        end
    end

    assign at_last = (idx_reg == last_reg);
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign res     = res_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wdata = alu_sum;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_ASSIGN:
            begin
                mem_we = 1'b1;
                mem_wdata = val_reg;
            end
            S_MOD:
            begin
                mem_we = (kind_reg == rast_pkg::KIND_ADD);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cfg_wr_en)
                begin
                    // length written mid-wipe: take it and start over
                    len_next = cfg_len;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    if (idx_reg == AW'(MAX_ELEMENTS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    // new length changes the layout: wipe everything
                    len_next   = cfg_len;
                    idx_next   = '0;
                    state_next = S_CLEAR;
                end
                else if (start)
                begin
                    kind_next = cmd.kind;
                    idx_next  = AW'(cmd.left_index);
                    last_next = AW'(cmd.right_index);
                    val_next  = {{32{cmd.operand_value[31]}}, cmd.operand_value};
                    acc_next  = '0;
                    if (bad_req)
                    begin
                        done_next = 1'b1;
                        res_next  = '{range_sum: '0, status: rast_pkg::STATUS_BAD};
                    end
                    else if (cmd.kind == rast_pkg::KIND_ASSIGN)
                    begin
                        state_next = S_ASSIGN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_ASSIGN:
            begin
                idx_next = idx_reg + AW'(1);
                if (at_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                acc_next = alu_sum;
                idx_next = idx_reg + AW'(1);
                if (at_last)
                begin
                    state_next = S_IDLE;
                    if (kind_reg == rast_pkg::KIND_QUERY)
                    begin
                        done_next = 1'b1;
                        res_next  = '{range_sum: alu_sum, status: rast_pkg::STATUS_OK};
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            len_reg   <= LW'(LEN_INIT);
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Spare opcode, outside the defined set: always answered as a bad request
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         CYCLE_LIMIT = 10_000_000;
    localparam int         RANDOM_ITEMS = 950;

    // Flat shadow of the array plus the queue of query answers still owed.
    // A lazy tree gives the same sums as the flat array, so the shadow is
    // simply per-element values with wrapping 64-bit arithmetic.
    class sum_scoreboard;
        logic [63:0]    elem_vals [rast_pkg::DEF_MAX_ELEMENTS];
        int             active_len;
        rast_pkg::res_t owed_results [$];
        int             mismatches;

        function new();
            active_len = rast_pkg::LEN_RESET;
            mismatches = 0;
            clear_elems();
        endfunction

        function void clear_elems();
            foreach (elem_vals[i]) elem_vals[i] = '0;
        endfunction

        // Length write clamps to 1 .. MAX and wipes the whole array
        function void set_length(logic [10:0] raw_len);
            int n;
            n = raw_len;
            if (n < 1) n = 1;
            if (n > rast_pkg::DEF_MAX_ELEMENTS) n = rast_pkg::DEF_MAX_ELEMENTS;
            active_len = n;
            clear_elems();
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        // Called for every accepted command transfer
        function void note_command(rast_pkg::cmd_t c);
            rast_pkg::res_t r;
            logic [63:0]    ext;
            logic [63:0]    acc;
            ext = {{32{c.operand_value[31]}}, c.operand_value};
            if (c.kind == KIND_SPARE || c.left_index > c.right_index
                || int'(c.right_index) >= active_len)
            begin
                r.range_sum  = '0;
                r.status     = rast_pkg::STATUS_BAD;
                owed_results = {owed_results, r};
            end
            else if (c.kind == rast_pkg::KIND_QUERY)
            begin
                acc = '0;
                for (int i = c.left_index; i <= c.right_index; i++)
                    acc = acc + elem_vals[i];
                r.range_sum  = acc;
                r.status     = rast_pkg::STATUS_OK;
                owed_results = {owed_results, r};
            end
            else
            begin
                for (int i = c.left_index; i <= c.right_index; i++)
                    elem_vals[i] = (c.kind == rast_pkg::KIND_ASSIGN) ?
                                   ext : elem_vals[i] + ext;
            end
        endfunction

        task check_result(rast_pkg::res_t got);
            rast_pkg::res_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("unexpected result sum=%0d st=%0b",
                                 got.range_sum, got.status));
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.range_sum !== want.range_sum)
                    report($sformatf("range_sum got %0d want %0d",
                                     got.range_sum, want.range_sum));
                if (got.status !== want.status)
                    report($sformatf("status got %0b want %0b",
                                     got.status, want.status));
            end
        endtask
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    rast_pkg::cmd_t cmd;
    logic           done;
    rast_pkg::res_t res;
    logic           cfg_wr_en;
    logic [10:0]    cfg_wr_data;

    sum_scoreboard sb;
    int            cycle_count = 0;

    range_add_assign_sum_tree DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: reads at the edge see pre-edge values, since both sides
    // update with nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_command(cmd);
        if (rst_n && done)
            sb.check_result(res);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold start high until the transfer edge; leaves start high so a
    // follow-on command can go straight out on the next call.
    task send_cmd(input rast_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task go_idle(input int gap);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Drain: everything owed has arrived and the sequencer has stopped
    task wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.owed_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Length write only from idle; a clearing pass follows, which the
    // next send waits out through busy.
    task write_length(input logic [10:0] raw_len);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= raw_len;
        @(posedge clk);
        sb.set_length(raw_len);
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    function automatic rast_pkg::cmd_t make_cmd(logic [1:0] k, int l, int r,
                                                logic [31:0] v);
        rast_pkg::cmd_t c;
        c.kind          = k;
        c.left_index    = l[9:0];
        c.right_index   = r[9:0];
        c.operand_value = v;
        return c;
    endfunction

    // Random operand: extremes and small values now and then, otherwise full-width noise
    function automatic logic [31:0] rand_operand();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed, mostly narrow ranges so the run stays short;
    // a few full-width sweeps and some malformed requests.
    function automatic rast_pkg::cmd_t rand_cmd(int len);
        int         pick;
        int         l;
        int         r;
        int         w;
        logic [1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 35)      k = rast_pkg::KIND_ADD;
        else if (pick < 60) k = rast_pkg::KIND_ASSIGN;
        else if (pick < 96) k = rast_pkg::KIND_QUERY;
        else                k = KIND_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 80)      w = $urandom_range(1, 16);
        else if (pick < 95) w = $urandom_range(1, 128);
        else                w = len;
        l = (w >= len) ? 0 : $urandom_range(0, len - 1);
        r = l + w - 1;
        if (r > len - 1) r = len - 1;
        pick = $urandom_range(0, 99);
        if (pick < 4 && l != r)
        begin
            w = l; l = r; r = w;             // reversed range
        end
        else if (pick < 8 && len < rast_pkg::DEF_MAX_ELEMENTS)
        begin
            r = $urandom_range(len, rast_pkg::DEF_MAX_ELEMENTS - 1);   // past the end
        end
        else if (pick < 10)
        begin
            l = $urandom_range(0, 1023);     // raw noise on both ends
            r = $urandom_range(0, 1023);
        end
        return make_cmd(k, l, r, rand_operand());
    endfunction

    // Sender in bursts, gaps between; some bursts run back to back
    task run_random(input int count);
        int left_to_send;
        int burst;
        left_to_send = count;
        while (left_to_send > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left_to_send > 0)
            begin
                send_cmd(rand_cmd(sb.active_len));
                burst--;
                left_to_send--;
            end
            if ($urandom_range(0, 3) != 0)
                go_idle($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full length after reset
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1023, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_ADD, 0, 1023, 32'h7FFF_FFFF));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1023, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_ASSIGN, 0, 1023, 32'h8000_0000));
        send_cmd(make_cmd(rast_pkg::KIND_ADD, 512, 1023, 32'hFFFF_FFFF));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 0, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 1023, 1023, 32'hFFFF_FFFF));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1023, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_ASSIGN, 1023, 1023, 32'h7FFF_FFFF));
        send_cmd(make_cmd(rast_pkg::KIND_ADD, 0, 0, 32'h1));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1023, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 5, 4, 32'h0));    // left above right
        send_cmd(make_cmd(rast_pkg::KIND_ADD, 700, 3, 32'h5));
        send_cmd(make_cmd(KIND_SPARE, 0, 1, 32'hFFFF_FFFF));      // unknown opcode
        go_idle(3);

        // Length written as zero clamps to one element
        write_length(11'd0);
        send_cmd(make_cmd(rast_pkg::KIND_ADD, 0, 0, 32'h8000_0000));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 0, 32'h0));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1, 32'h0));    // runs past the end
        send_cmd(make_cmd(rast_pkg::KIND_ASSIGN, 1023, 1023, 32'h1));
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 0, 32'h0));    // assign above was refused
        run_random(60);

        // Hold off until every owed answer is back, then carry on
        wait_drained();
        run_random(60);

        // All ones clamps to the maximum
        write_length(11'h7FF);
        send_cmd(make_cmd(rast_pkg::KIND_QUERY, 0, 1023, 32'h0)); // cleared by the write
        run_random(250);

        write_length(11'd1);
        run_random(60);
        write_length(11'($urandom_range(2, 1023)));
        run_random(200);
        write_length(11'd1024);
        run_random(200);
        write_length(11'd1025);
        run_random(RANDOM_ITEMS - 830);

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.owed_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_results.size()));
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rast_pkg.sv
sv/rast_mem.sv
sv/rast_alu.sv
sv/range_add_assign_sum_tree.sv
dv/tb_top.sv
